>>> rtl/m6502_pkg.sv
// ----------------------------------------------------------------------------
// m6502_pkg
// Shared types, codes and decode tables for the 6502 subset core.
// ----------------------------------------------------------------------------
package m6502_pkg;

  typedef enum logic [1:0] {
    SEQ_RESET = 2'd0,
    SEQ_INSN  = 2'd1,
    SEQ_NMI   = 2'd2
  } seq_mode_t;

  typedef enum logic [3:0] {
    AM_BAD  = 4'd0,
    AM_IMP  = 4'd1,
    AM_IMM  = 4'd2,
    AM_ZP   = 4'd3,
    AM_ZPX  = 4'd4,
    AM_ABS  = 4'd5,
    AM_ABSX = 4'd6,
    AM_INDY = 4'd7,
    AM_REL  = 4'd8,
    AM_SPEC = 4'd9
  } addr_mode_t;

  // special step codes
  localparam logic [3:0] STEP_READ = 4'd8;
  localparam logic [3:0] STEP_RMW  = 4'd9;
  localparam logic [3:0] STEP_DONE = 4'd15;

  localparam logic [7:0]  RST_STATUS = 8'h34;
  localparam logic [7:0]  RST_SP     = 8'hFD;
  localparam logic [15:0] VEC_NMI    = 16'hFFFA;
  localparam logic [15:0] VEC_RESET  = 16'hFFFC;
  localparam logic [15:0] VEC_IRQ    = 16'hFFFE;
  localparam logic [7:0]  STACK_PAGE = 8'h01;

  // processor state carried between cycles
  typedef struct packed {
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  p;
    logic [7:0]  s;
    logic [15:0] pc;
    logic [7:0]  op;
    logic [15:0] lat;
    logic [3:0]  step;
    logic        nmi;
    seq_mode_t   mode;
  } cpu_state_t;

  // one bus cycle result
  typedef struct packed {
    logic [15:0] addr;
    logic        wr;
    logic [7:0]  wdata;
    logic        iend;
    logic [3:0]  cyc;
    logic        bad;
  } bus_res_t;

  function automatic logic [3:0] base_cycles(input logic [7:0] op);
    unique case (op)
      8'h00: base_cycles = 4'd7;
      8'h06, 8'h66, 8'hC6, 8'hB1: base_cycles = 4'd5;
      8'h20, 8'h40, 8'h60, 8'h91, 8'hCE: base_cycles = 4'd6;
      8'h68, 8'h8D, 8'hAD, 8'hAE, 8'hB4, 8'hBD: base_cycles = 4'd4;
      8'h05, 8'h08, 8'h45, 8'h48, 8'h4C, 8'h84, 8'h85, 8'h86, 8'hA5, 8'hA6:
        base_cycles = 4'd3;
      8'h0A, 8'h10, 8'h18, 8'h29, 8'h2A, 8'h38, 8'h49, 8'h4A, 8'h78, 8'h88,
      8'h9A, 8'hA0, 8'hA2, 8'hA9, 8'hAA, 8'hC8, 8'hC9, 8'hD0, 8'hD8, 8'hE8,
      8'hF0: base_cycles = 4'd2;
      default: base_cycles = 4'd0;
    endcase
  endfunction

  function automatic addr_mode_t addr_mode(input logic [7:0] op);
    unique case (op)
      8'h0A, 8'h18, 8'h2A, 8'h38, 8'h4A, 8'h78, 8'h88, 8'h9A, 8'hAA, 8'hC8,
      8'hD8, 8'hE8: addr_mode = AM_IMP;
      8'h29, 8'h49, 8'hA0, 8'hA2, 8'hA9, 8'hC9: addr_mode = AM_IMM;
      8'h05, 8'h06, 8'h45, 8'h66, 8'h84, 8'h85, 8'h86, 8'hA5, 8'hA6, 8'hC6:
        addr_mode = AM_ZP;
      8'hB4: addr_mode = AM_ZPX;
      8'h4C, 8'h8D, 8'hAD, 8'hAE, 8'hCE: addr_mode = AM_ABS;
      8'hBD: addr_mode = AM_ABSX;
      8'h91, 8'hB1: addr_mode = AM_INDY;
      8'h10, 8'hD0, 8'hF0: addr_mode = AM_REL;
      8'h00, 8'h08, 8'h20, 8'h40, 8'h48, 8'h60, 8'h68: addr_mode = AM_SPEC;
      default: addr_mode = AM_BAD;
    endcase
  endfunction

endpackage

>>> rtl/m6502_step.sv
// ----------------------------------------------------------------------------
// m6502_step
// Combinational next-state and bus-access logic for one bus cycle.
// ----------------------------------------------------------------------------
module m6502_step
  import m6502_pkg::*;
(
  input  cpu_state_t cur,
  input  logic [7:0] rdata,
  input  logic       nmi_req,
  output cpu_state_t nxt,
  output bus_res_t   res
);

  always_comb begin
    cpu_state_t st;
    bus_res_t   r;
    logic [7:0]  d;
    logic [3:0]  cyc;
    logic [7:0]  v;
    logic [15:0] ea;
    logic [15:0] t;
    logic        take;
    logic        do_bnd;
    logic [3:0]  bcyc;
    logic        ent;
    logic [2:0]  k;
    logic        brk;
    logic [15:0] vec;
    logic        acc_ea;
    logic [15:0] aea;
    logic [3:0]  acyc;
    logic        do_read;
    logic [7:0]  rv;

    st = cur;
    r  = '0;
    d  = rdata;
    cyc = base_cycles(cur.op);
    v = 8'h00; ea = 16'h0000; t = 16'h0000; take = 1'b0;
    do_bnd = 1'b0; bcyc = 4'd0; ent = 1'b0; k = 3'd0; brk = 1'b0; vec = VEC_NMI;
    acc_ea = 1'b0; aea = 16'h0000; acyc = 4'd0; do_read = 1'b0; rv = 8'h00;
    if (nmi_req) st.nmi = 1'b1;

    // sequencer
    unique case (cur.mode)
      SEQ_RESET: begin
        if (cur.step == 4'd0) begin
          r.addr = VEC_RESET; st.step = 4'd1;
        end else if (cur.step == 4'd1) begin
          st.lat = {8'h00, d}; r.addr = VEC_RESET + 16'd1; st.step = 4'd2;
        end else begin
          st.pc = {d, cur.lat[7:0]}; do_bnd = 1'b1; bcyc = 4'd7;
        end
      end
      SEQ_NMI: begin
        ent = 1'b1; k = cur.step[2:0]; vec = VEC_NMI;
      end
      default: begin
        if (cur.step == 4'd0) begin
          // opcode decode
          st.op = d;
          cyc = base_cycles(d);
          unique case (addr_mode(d))
            AM_BAD: begin r.bad = 1'b1; do_bnd = 1'b1; bcyc = 4'd2; end
            AM_IMP: begin
              do_bnd = 1'b1; bcyc = cyc;
              unique case (d)
                8'h0A: begin st.p[0] = cur.a[7]; st.a = {cur.a[6:0], 1'b0}; end
                8'h18: st.p[0] = 1'b0;
                8'h2A: begin st.p[0] = cur.a[7]; st.a = {cur.a[6:0], cur.p[0]}; end
                8'h38: st.p[0] = 1'b1;
                8'h4A: begin st.p[0] = cur.a[0]; st.a = {1'b0, cur.a[7:1]}; end
                8'h78: st.p[2] = 1'b1;
                8'h88: st.y = cur.y - 8'd1;
                8'h9A: st.s = cur.x;
                8'hAA: st.x = cur.a;
                8'hC8: st.y = cur.y + 8'd1;
                8'hD8: st.p[3] = 1'b0;
                8'hE8: st.x = cur.x + 8'd1;
                default: ;
              endcase
              unique case (d)
                8'h0A, 8'h2A, 8'h4A: begin
                  st.p[7] = st.a[7]; st.p[1] = (st.a == 8'h00);
                end
                8'h88, 8'hC8: begin st.p[7] = st.y[7]; st.p[1] = (st.y == 8'h00); end
                8'hAA, 8'hE8: begin st.p[7] = st.x[7]; st.p[1] = (st.x == 8'h00); end
                default: ;
              endcase
            end
            AM_SPEC: begin
              st.step = 4'd1;
              unique case (d)
                8'h00: begin
                  st.pc = cur.pc + 16'd1;
                  r.addr = {STACK_PAGE, cur.s}; r.wr = 1'b1; r.wdata = st.pc[15:8];
                  st.s = cur.s - 8'd1;
                end
                8'h08, 8'h48: begin
                  r.addr = {STACK_PAGE, cur.s}; r.wr = 1'b1;
                  r.wdata = (d == 8'h08) ? (cur.p | 8'h30) : cur.a;
                  st.s = cur.s - 8'd1; st.lat = 16'd3; st.step = STEP_DONE;
                end
                8'h20: begin r.addr = cur.pc; st.pc = cur.pc + 16'd1; end
                default: begin
                  st.s = cur.s + 8'd1; r.addr = {STACK_PAGE, st.s};
                end
              endcase
            end
            default: begin
              r.addr = cur.pc; st.pc = cur.pc + 16'd1; st.step = 4'd1;
            end
          endcase
        end else if (cur.step == STEP_READ) begin
          do_read = 1'b1; rv = d; do_bnd = 1'b1; bcyc = cur.lat[3:0];
        end else if (cur.step == STEP_RMW) begin
          // read-modify-write
          if (cur.op == 8'h06) begin
            st.p[0] = d[7]; v = {d[6:0], 1'b0};
          end else if (cur.op == 8'h66) begin
            v = {cur.p[0], d[7:1]}; st.p[0] = d[0];
          end else begin
            v = d - 8'd1;
          end
          st.p[7] = v[7]; st.p[1] = (v == 8'h00);
          r.addr = cur.lat; r.wr = 1'b1; r.wdata = v;
          st.lat = {12'h000, cyc}; st.step = STEP_DONE;
        end else if (cur.step == STEP_DONE) begin
          do_bnd = 1'b1; bcyc = cur.lat[3:0];
        end else begin
          unique case (addr_mode(cur.op))
            AM_IMM: begin do_read = 1'b1; rv = d; do_bnd = 1'b1; bcyc = cyc; end
            AM_ZP: begin acc_ea = 1'b1; aea = {8'h00, d}; acyc = cyc; end
            AM_ZPX: begin acc_ea = 1'b1; aea = {8'h00, d + cur.x}; acyc = cyc; end
            AM_REL: begin
              take = (cur.op == 8'h10) ? !cur.p[7] :
                     (cur.op == 8'hD0) ? !cur.p[1] : cur.p[1];
              t = cur.pc + {{8{d[7]}}, d};
              bcyc = cyc;
              if (take) begin
                bcyc = (cur.pc[15:8] != t[15:8]) ? 4'd4 : 4'd3;
                st.pc = t;
              end
              do_bnd = 1'b1;
            end
            AM_ABS, AM_ABSX: begin
              if (cur.step == 4'd1) begin
                st.lat = {8'h00, d}; r.addr = cur.pc; st.pc = cur.pc + 16'd1;
                st.step = 4'd2;
              end else begin
                ea = {d, cur.lat[7:0]};
                t = ea + {8'h00, cur.x};
                if (cur.op == 8'h4C) begin
                  st.pc = ea; do_bnd = 1'b1; bcyc = cyc;
                end else if (cur.op == 8'hBD) begin
                  acc_ea = 1'b1; aea = t;
                  acyc = cyc + ((ea[15:8] != t[15:8]) ? 4'd1 : 4'd0);
                end else begin
                  acc_ea = 1'b1; aea = ea; acyc = cyc;
                end
              end
            end
            AM_INDY: begin
              if (cur.step == 4'd1) begin
                st.lat = {8'h00, d}; r.addr = {8'h00, d}; st.step = 4'd2;
              end else if (cur.step == 4'd2) begin
                st.lat = {cur.lat[7:0], d};
                r.addr = {8'h00, cur.lat[7:0] + 8'd1}; st.step = 4'd3;
              end else begin
                ea = {d, cur.lat[7:0]};
                t = ea + {8'h00, cur.y};
                acc_ea = 1'b1; aea = t;
                acyc = cyc + ((cur.op == 8'hB1 && ea[15:8] != t[15:8]) ? 4'd1 : 4'd0);
              end
            end
            AM_SPEC: begin
              unique case (cur.op)
                8'h00: begin
                  ent = 1'b1; k = cur.step[2:0] - 3'd1; brk = 1'b1; vec = VEC_IRQ;
                end
                8'h20: begin
                  if (cur.step == 4'd1) begin
                    st.lat = {8'h00, d};
                    r.addr = {STACK_PAGE, cur.s}; r.wr = 1'b1; r.wdata = cur.pc[15:8];
                    st.s = cur.s - 8'd1; st.step = 4'd2;
                  end else if (cur.step == 4'd2) begin
                    r.addr = {STACK_PAGE, cur.s}; r.wr = 1'b1; r.wdata = cur.pc[7:0];
                    st.s = cur.s - 8'd1; st.step = 4'd3;
                  end else if (cur.step == 4'd3) begin
                    r.addr = cur.pc; st.step = 4'd4;
                  end else begin
                    st.pc = {d, cur.lat[7:0]}; do_bnd = 1'b1; bcyc = 4'd6;
                  end
                end
                8'h60: begin
                  if (cur.step == 4'd1) begin
                    st.lat = {8'h00, d}; st.s = cur.s + 8'd1;
                    r.addr = {STACK_PAGE, st.s}; st.step = 4'd2;
                  end else begin
                    st.pc = {d, cur.lat[7:0]} + 16'd1; do_bnd = 1'b1; bcyc = 4'd6;
                  end
                end
                8'h40: begin
                  if (cur.step == 4'd1) begin
                    st.p = (d & 8'hCF) | (cur.p & 8'h30);
                    st.s = cur.s + 8'd1; r.addr = {STACK_PAGE, st.s}; st.step = 4'd2;
                  end else if (cur.step == 4'd2) begin
                    st.lat = {8'h00, d};
                    st.s = cur.s + 8'd1; r.addr = {STACK_PAGE, st.s}; st.step = 4'd3;
                  end else begin
                    st.pc = {d, cur.lat[7:0]}; do_bnd = 1'b1; bcyc = 4'd6;
                  end
                end
                8'h68: begin do_read = 1'b1; rv = d; do_bnd = 1'b1; bcyc = 4'd4; end
                default: begin do_bnd = 1'b1; bcyc = 4'd2; end
              endcase
            end
            default: begin do_bnd = 1'b1; bcyc = 4'd2; end
          endcase
        end
      end
    endcase

    // effective address access
    if (acc_ea) begin
      unique case (cur.op)
        8'h84, 8'h85, 8'h86, 8'h8D, 8'h91: begin
          r.addr = aea; r.wr = 1'b1;
          r.wdata = (cur.op == 8'h84) ? cur.y : (cur.op == 8'h86) ? cur.x : cur.a;
          st.lat = {12'h000, acyc}; st.step = STEP_DONE;
        end
        8'h06, 8'h66, 8'hC6, 8'hCE: begin
          r.addr = aea; st.lat = aea; st.step = STEP_RMW;
        end
        default: begin
          r.addr = aea; st.lat = {12'h000, acyc}; st.step = STEP_READ;
        end
      endcase
    end

    // load / logic result
    if (do_read) begin
      unique case (cur.op)
        8'h05: st.a = cur.a | rv;
        8'h29: st.a = cur.a & rv;
        8'h45, 8'h49: st.a = cur.a ^ rv;
        8'hA0, 8'hB4: st.y = rv;
        8'hA2, 8'hA6, 8'hAE: st.x = rv;
        8'hA5, 8'hA9, 8'hAD, 8'hBD, 8'hB1, 8'h68: st.a = rv;
        default: ;
      endcase
      unique case (cur.op)
        8'h05, 8'h29, 8'h45, 8'h49: begin
          st.p[7] = st.a[7]; st.p[1] = (st.a == 8'h00);
        end
        8'hA0, 8'hB4, 8'hA2, 8'hA6, 8'hAE, 8'hA5, 8'hA9, 8'hAD, 8'hBD, 8'hB1,
        8'h68: begin
          st.p[7] = rv[7]; st.p[1] = (rv == 8'h00);
        end
        8'hC9: begin
          st.p[0] = (cur.a >= rv); v = cur.a - rv;
          st.p[7] = v[7]; st.p[1] = (v == 8'h00);
        end
        default: ;
      endcase
    end

    // interrupt / BRK entry steps
    if (ent) begin
      unique case (k)
        3'd0: begin
          r.addr = {STACK_PAGE, cur.s}; r.wr = 1'b1; r.wdata = cur.pc[7:0];
          st.s = cur.s - 8'd1; st.step = cur.step + 4'd1;
        end
        3'd1: begin
          r.addr = {STACK_PAGE, cur.s}; r.wr = 1'b1;
          r.wdata = brk ? (cur.p | 8'h30) : ((cur.p & 8'hEF) | 8'h20);
          st.s = cur.s - 8'd1; st.p[2] = 1'b1; st.step = cur.step + 4'd1;
        end
        3'd2: begin r.addr = vec; st.step = cur.step + 4'd1; end
        3'd3: begin
          st.lat = {8'h00, d}; r.addr = vec + 16'd1; st.step = cur.step + 4'd1;
        end
        default: begin
          if (k == 3'd4) st.pc = {d, cur.lat[7:0]};
          do_bnd = 1'b1; bcyc = 4'd7;
        end
      endcase
    end

    // instruction boundary: NMI entry or next opcode fetch
    if (do_bnd) begin
      r.iend = 1'b1; r.cyc = bcyc; st.step = 4'd0;
      if (st.nmi) begin
        st.nmi = 1'b0; st.mode = SEQ_NMI;
        r.addr = {STACK_PAGE, st.s}; r.wr = 1'b1; r.wdata = st.pc[15:8];
        st.s = st.s - 8'd1;
      end else begin
        st.mode = SEQ_INSN;
        r.addr = st.pc; r.wr = 1'b0; r.wdata = 8'h00; st.pc = st.pc + 16'd1;
      end
    end

    nxt = st;
    res = r;
  end

endmodule

>>> rtl/mos6502_subset_cpu_core.sv
// ----------------------------------------------------------------------------
// mos6502_subset_cpu_core
// 6502 subset core, one bus cycle per input transfer.
// ----------------------------------------------------------------------------
// Each input transfer is one bus cycle (the byte answering the previous read
// and the NMI line) and yields exactly one output transfer describing the next
// access and the registers. The decode and execute logic sits between the
// state register and the output register, so a result is offered in the clock
// after its input transfer. A new input transfer is taken whenever the output
// register is empty or is emptied in the same clock, which gives one transfer
// per clock back to back; while a result waits unaccepted the input stalls.
// After reset the first transfer issues the reset vector read at FFFC.
module mos6502_subset_cpu_core
  import m6502_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // read_data
  input  logic        in_tuser,   // nmi_request
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [87:0] out_tdata,  // bus_address, bus_write, write_data,
                                  // instruction_end, cycles_charged, bad_opcode,
                                  // acc, x, y, status, stack, pc, zero fill
  output logic        out_tlast   // instruction_end
);

  cpu_state_t cur_r, nxt;
  bus_res_t   res;
  logic       ovalid_r;
  logic [87:0] odata_r;
  logic       olast_r;
  logic       xfer;

  m6502_step u_step (
    .cur     (cur_r),
    .rdata   (in_tdata),
    .nmi_req (in_tuser),
    .nxt     (nxt),
    .res     (res)
  );

  assign in_tready = !ovalid_r || out_tready;
  assign xfer = in_tvalid && in_tready;

  // processor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= '{a: 8'h00, x: 8'h00, y: 8'h00, p: RST_STATUS, s: RST_SP,
                 pc: 16'h0000, op: 8'h00, lat: 16'h0000, step: 4'd0,
                 nmi: 1'b0, mode: SEQ_RESET};
    end else if (xfer) begin
      cur_r <= nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (in_tready) begin
      ovalid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer) begin
      odata_r <= {1'b0, nxt.pc, nxt.s, nxt.p, nxt.y, nxt.x, nxt.a,
                  res.bad, res.cyc, res.iend, res.wdata, res.wr, res.addr};
      olast_r <= res.iend;
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign out_tlast  = olast_r;

  // boundary marks always carry a cost; mid-instruction results never do
  a_end_cyc: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && res.iend |-> res.cyc != 4'd0) else $error("boundary without cost");
  a_mid_cyc: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && !res.iend |-> res.cyc == 4'd0) else $error("cost off boundary");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("output changed");
  a_nmi_clr: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && res.iend && nxt.mode == SEQ_NMI |-> !nxt.nmi) else $error("nmi kept");

endmodule
